// ===== rtl/swm_pkg.sv =====
// shared constants, types and codes for the two-dimensional sliding window minimum unit
// no dependencies; every other rtl file but swm_ram imports this package

package swm_pkg;

   // sizing of the block
   localparam int PIXEL_BITS        = 32;
   localparam int MAX_IMAGE_WIDTH   = 1024;
   localparam int MAX_IMAGE_HEIGHT  = 4096;
   localparam int MAX_WINDOW_HEIGHT = 32;
   localparam int MAX_WINDOW_WIDTH  = 32;

   // register field widths
   localparam int IMAGE_WIDTH_BITS  = 11;
   localparam int IMAGE_HEIGHT_BITS = 13;
   localparam int WINDOW_BITS       = 6;
   localparam int CSR_INDEX_BITS    = 3;
   localparam int CSR_DATA_BITS     = 13;

   // stream data width, pixel padded to whole bytes
   localparam int TDATA_BITS = ((PIXEL_BITS + 7) / 8) * 8;

   // position counters
   localparam int COL_BITS = (MAX_IMAGE_WIDTH > 1) ? $clog2(MAX_IMAGE_WIDTH) : 1;
   localparam int ROW_BITS = (MAX_IMAGE_HEIGHT > 1) ? $clog2(MAX_IMAGE_HEIGHT) : 1;

   // line buffers of horizontal minima, one per earlier row the window can reach
   localparam int LINE_COUNT = (MAX_WINDOW_HEIGHT > 1) ? MAX_WINDOW_HEIGHT - 1 : 1;
   localparam int SLOT_BITS  = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
   localparam int AGE_BITS   = $clog2(LINE_COUNT + 1);

   // both minimum trees share one shape
   localparam int TREE_SPAN   = (MAX_WINDOW_WIDTH > MAX_WINDOW_HEIGHT) ?
                                MAX_WINDOW_WIDTH : MAX_WINDOW_HEIGHT;
   localparam int TREE_LEVELS = (TREE_SPAN > 1) ? $clog2(TREE_SPAN) : 1;
   localparam int TREE_LEAVES = 1 << TREE_LEVELS;

   // pipeline stage numbers, stage 0 is loaded when a request is taken
   localparam int WRITE_STAGE = TREE_LEVELS;
   localparam int VLEAF_STAGE = TREE_LEVELS + 1;
   localparam int LAST_STAGE  = 2 * TREE_LEVELS + 1;
   localparam int PIPE_STAGES = LAST_STAGE + 1;

   // result queue, deep enough to cover every request in flight
   localparam int QUEUE_DEPTH = 1 << $clog2(PIPE_STAGES + 4);
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int OCC_BITS    = $clog2(QUEUE_DEPTH + 1);

   typedef logic signed [PIXEL_BITS-1:0] pixel_type;

   localparam pixel_type PIX_MAX = {1'b0, {(PIXEL_BITS - 1){1'b1}}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_IMAGE_WIDTH,
      CSR_IMAGE_HEIGHT,
      CSR_WINDOW_HEIGHT,
      CSR_WINDOW_WIDTH
   } csr_index_type;

   // sizes as held, already forced into their legal ranges
   typedef struct packed {
      logic [IMAGE_WIDTH_BITS-1:0]  image_width;
      logic [IMAGE_HEIGHT_BITS-1:0] image_height;
      logic [WINDOW_BITS-1:0]       window_height;
      logic [WINDOW_BITS-1:0]       window_width;
   } cfg_type;

   // per-request control that travels down the pipeline
   typedef struct packed {
      logic                  do_hmin;
      logic                  emit;
      logic                  row_end;
      logic                  frame_end;
      logic [COL_BITS-1:0]   col;
      logic [SLOT_BITS-1:0]  slot;
      logic [LINE_COUNT-1:0] line_use;
   } meta_type;

   typedef struct packed {
      logic      frame_end;
      logic      row_end;
      pixel_type window_min;
   } rsp_item_type;

endpackage

// ===== rtl/sliding_window_min_2d_unit.sv =====
// top level of the two-dimensional sliding window minimum unit
// depends on swm_pkg, swm_position, swm_min_tree, swm_ram and swm_out_queue
//
// Pixels enter in raster order, one per cycle at full rate. For every window of
// window_height rows by window_width columns that lies inside the image, one result
// leaves when the window's bottom-right pixel has arrived; tlast marks the last window
// of an output row and tuser the last of the frame. A request reaches the result queue
// through the horizontal minimum tree, the line buffer read and the vertical minimum
// tree, one compare level per stage in each tree. The sustained rate is one pixel per
// cycle while req_tready stays high; each of the LINE_COUNT line rams can take one
// write and one read every cycle. A queue of QUEUE_DEPTH results lets requests keep
// coming while results wait; req_tready falls only when that many requests are in
// flight or waiting. Any size write restarts the frame; the line buffers need no
// clearing after reset, as every entry is written before it is read within a frame.

module sliding_window_min_2d_unit
   import swm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request: tdata[31:0] pixel, signed
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [TDATA_BITS-1:0]     req_tdata,
   // result: tdata[31:0] window_min, signed; tlast row_end; tuser frame_end
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [TDATA_BITS-1:0]     rsp_tdata,
   output logic                      rsp_tlast,
   output logic                      rsp_tuser,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic            accept;
   cfg_type         cfg;
   meta_type        pos_meta;
   meta_type        meta_ff [PIPE_STAGES];
   logic            valid_ff [PIPE_STAGES];
   pixel_type       recent_ff [MAX_WINDOW_WIDTH];
   pixel_type       hleaf [TREE_LEAVES];
   pixel_type       vleaf [TREE_LEAVES];
   pixel_type       hmin, vmin, hmin_ff;
   pixel_type       line_rd [LINE_COUNT];
   logic            line_we [LINE_COUNT];
   logic            push, drop;
   rsp_item_type    push_item, rsp_item;

   assign accept = req_tvalid && req_tready;

   swm_position u_position (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .meta      (pos_meta)
   );

   // newest pixels of the current row
   always_ff @(posedge clock) begin
      if (accept) begin
         recent_ff[0] <= req_tdata[PIXEL_BITS-1:0];
         for (int i = 1; i < MAX_WINDOW_WIDTH; i++) begin
            recent_ff[i] <= recent_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      meta_ff[0] <= pos_meta;
      for (int k = 1; k < PIPE_STAGES; k++) begin
         meta_ff[k] <= meta_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         valid_ff[0] <= accept;
         for (int k = 1; k < PIPE_STAGES; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // pixels outside the window width read as the largest value
   always_comb begin
      for (int i = 0; i < TREE_LEAVES; i++) begin
         hleaf[i] = PIX_MAX;
      end
      for (int i = 0; i < MAX_WINDOW_WIDTH; i++) begin
         if (i < int'(cfg.window_width)) begin
            hleaf[i] = recent_ff[i];
         end
      end
   end

   swm_min_tree u_hmin_tree (
      .clock    (clock),
      .leaf     (hleaf),
      .tree_min (hmin)
   );

   always_comb begin
      for (int j = 0; j < LINE_COUNT; j++) begin
         line_we[j] = valid_ff[WRITE_STAGE] && meta_ff[WRITE_STAGE].do_hmin
                      && (meta_ff[WRITE_STAGE].slot == SLOT_BITS'(j));
      end
   end

   // one line of horizontal minima per earlier row, read and written in the same stage
   for (genvar j = 0; j < LINE_COUNT; j++) begin : g_line
      swm_ram #(
         .WIDTH (PIXEL_BITS),
         .DEPTH (MAX_IMAGE_WIDTH)
      ) u_line (
         .clock   (clock),
         .wr_en   (line_we[j]),
         .wr_addr (meta_ff[WRITE_STAGE].col),
         .wr_data (hmin),
         .rd_addr (meta_ff[WRITE_STAGE].col),
         .rd_data (line_rd[j])
      );
   end

   always_ff @(posedge clock) begin
      hmin_ff <= hmin;
   end

   // order of rows does not matter for a minimum, so lines feed the tree unrotated
   always_comb begin
      for (int i = 0; i < TREE_LEAVES; i++) begin
         vleaf[i] = PIX_MAX;
      end
      vleaf[0] = hmin_ff;
      for (int j = 0; j < LINE_COUNT; j++) begin
         if (meta_ff[VLEAF_STAGE].line_use[j]) begin
            vleaf[j+1] = line_rd[j];
         end
      end
   end

   swm_min_tree u_vmin_tree (
      .clock    (clock),
      .leaf     (vleaf),
      .tree_min (vmin)
   );

   assign push = valid_ff[LAST_STAGE] && meta_ff[LAST_STAGE].emit;
   assign drop = valid_ff[LAST_STAGE] && !meta_ff[LAST_STAGE].emit;

   always_comb begin
      push_item.window_min = vmin;
      push_item.row_end    = meta_ff[LAST_STAGE].row_end;
      push_item.frame_end  = meta_ff[LAST_STAGE].frame_end;
   end

   swm_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .drop       (drop),
      .push       (push),
      .push_item  (push_item),
      .req_ready  (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = TDATA_BITS'($unsigned(rsp_item.window_min));
   assign rsp_tlast = rsp_item.row_end;
   assign rsp_tuser = rsp_item.frame_end;

endmodule

// ===== rtl/swm_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// read-first on a same-address collision; no package dependency

module swm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/swm_min_tree.sv =====
// pipelined signed minimum tree, one compare level per register stage
// depends on swm_pkg for the leaf count and pixel type

module swm_min_tree
   import swm_pkg::*;
(
   input  logic      clock,
   input  pixel_type leaf [TREE_LEAVES],
   output pixel_type tree_min
);

   // heap layout: nodes 1 .. leaves-1 are registers, the rest are the leaves
   pixel_type node_ff [1:TREE_LEAVES-1];
   pixel_type heap    [1:2*TREE_LEAVES-1];

   always_comb begin
      for (int k = 1; k < 2 * TREE_LEAVES; k++) begin
         if (k < TREE_LEAVES) begin
            heap[k] = node_ff[k];
         end else begin
            heap[k] = leaf[k - TREE_LEAVES];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k < TREE_LEAVES; k++) begin
         node_ff[k] <= (heap[2*k+1] < heap[2*k]) ? heap[2*k+1] : heap[2*k];
      end
   end

   assign tree_min = node_ff[1];

endmodule

// ===== rtl/swm_position.sv =====
// size registers, raster position counters and per-request window flags
// depends on swm_pkg for the register codes, sizes and structs

module swm_position
   import swm_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg,
   output meta_type                  meta
);

   cfg_type              cfg_ff, cfg_in;
   logic [COL_BITS-1:0]  col_ff, col_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [SLOT_BITS-1:0] slot_ff, slot_in;
   logic                 last_col, last_row, restart;

   function automatic logic [IMAGE_WIDTH_BITS-1:0] clamp_width(
      input logic [IMAGE_WIDTH_BITS-1:0] v);
      if (v == '0) return IMAGE_WIDTH_BITS'(1);
      else if (int'(v) > MAX_IMAGE_WIDTH) return IMAGE_WIDTH_BITS'(MAX_IMAGE_WIDTH);
      else return v;
   endfunction

   function automatic logic [IMAGE_HEIGHT_BITS-1:0] clamp_height(
      input logic [IMAGE_HEIGHT_BITS-1:0] v);
      if (v == '0) return IMAGE_HEIGHT_BITS'(1);
      else if (int'(v) > MAX_IMAGE_HEIGHT) return IMAGE_HEIGHT_BITS'(MAX_IMAGE_HEIGHT);
      else return v;
   endfunction

   function automatic logic [WINDOW_BITS-1:0] clamp_window(
      input logic [WINDOW_BITS-1:0] v, input int hi);
      if (v == '0) return WINDOW_BITS'(1);
      else if (int'(v) > hi) return WINDOW_BITS'(hi);
      else return v;
   endfunction

   assign last_col = (IMAGE_WIDTH_BITS'(col_ff) == cfg_ff.image_width - 1'b1);
   assign last_row = (IMAGE_HEIGHT_BITS'(row_ff) == cfg_ff.image_height - 1'b1);

   always_comb begin
      cfg_in  = cfg_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      restart = 1'b0;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               cfg_in.image_width = clamp_width(csr_wdata[IMAGE_WIDTH_BITS-1:0]);
               restart = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               cfg_in.image_height = clamp_height(csr_wdata[IMAGE_HEIGHT_BITS-1:0]);
               restart = 1'b1;
            end
            CSR_WINDOW_HEIGHT: begin
               cfg_in.window_height = clamp_window(csr_wdata[WINDOW_BITS-1:0],
                                                   MAX_WINDOW_HEIGHT);
               restart = 1'b1;
            end
            CSR_WINDOW_WIDTH: begin
               cfg_in.window_width = clamp_window(csr_wdata[WINDOW_BITS-1:0],
                                                  MAX_WINDOW_WIDTH);
               restart = 1'b1;
            end
            default: ;
         endcase
         // any size write starts a fresh frame
         if (restart) begin
            col_in  = '0;
            row_in  = '0;
            slot_in = '0;
         end
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in  = '0;
               slot_in = '0;
            end else begin
               row_in  = row_ff + 1'b1;
               slot_in = (int'(slot_ff) == LINE_COUNT - 1) ? '0 : slot_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= IMAGE_WIDTH_BITS'(1024);
         cfg_ff.image_height  <= IMAGE_HEIGHT_BITS'(1024);
         cfg_ff.window_height <= WINDOW_BITS'(3);
         cfg_ff.window_width  <= WINDOW_BITS'(3);
         col_ff               <= '0;
         row_ff               <= '0;
         slot_ff              <= '0;
      end else begin
         cfg_ff  <= cfg_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         slot_ff <= slot_in;
      end
   end

   // flags for the pixel now at the input
   always_comb begin
      logic [AGE_BITS-1:0] age;
      meta.do_hmin   = (IMAGE_WIDTH_BITS'(col_ff) + 1'b1)
                       >= IMAGE_WIDTH_BITS'(cfg_ff.window_width);
      meta.emit      = meta.do_hmin && ((IMAGE_HEIGHT_BITS'(row_ff) + 1'b1)
                       >= IMAGE_HEIGHT_BITS'(cfg_ff.window_height));
      meta.row_end   = last_col;
      meta.frame_end = last_col && last_row;
      meta.col       = col_ff;
      meta.slot      = slot_ff;
      // a line holds the row that many rows back; its own slot is the oldest
      for (int j = 0; j < LINE_COUNT; j++) begin
         if (int'(slot_ff) > j) begin
            age = AGE_BITS'(slot_ff) - AGE_BITS'(j);
         end else begin
            age = AGE_BITS'(slot_ff) + AGE_BITS'(LINE_COUNT) - AGE_BITS'(j);
         end
         meta.line_use[j] = int'(age) < int'(cfg_ff.window_height);
      end
   end

   assign cfg = cfg_ff;

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      IMAGE_WIDTH_BITS'(col_ff) < cfg_ff.image_width)
      else $error("column counter beyond image width");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      IMAGE_HEIGHT_BITS'(row_ff) < cfg_ff.image_height)
      else $error("row counter beyond image height");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      int'(slot_ff) < LINE_COUNT)
      else $error("line slot beyond line count");

endmodule

// ===== rtl/swm_out_queue.sv =====
// result queue with request credits, so the input keeps flowing while results wait
// depends on swm_pkg for the queue depth and result struct

module swm_out_queue
   import swm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  logic         drop,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         req_ready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output rsp_item_type rsp_item
);

   rsp_item_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [OCC_BITS-1:0]  count_ff, count_in;
   logic [OCC_BITS-1:0]  occ_ff, occ_in;
   logic                 pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_item   = entry_ff[rd_ptr_ff];
   // every request in flight owns one slot until it leaves without a result or is taken
   assign req_ready  = (int'(occ_ff) < QUEUE_DEPTH);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + OCC_BITS'(push) - OCC_BITS'(pop);
      occ_in    = occ_ff + OCC_BITS'(accept) - OCC_BITS'(drop) - OCC_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         occ_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      int'(occ_ff) <= QUEUE_DEPTH)
      else $error("request credits overrun");

   a_count_covered: assert property (@(posedge clock) disable iff (reset)
      count_ff <= occ_ff)
      else $error("more results held than requests in flight");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (int'(count_ff) < QUEUE_DEPTH) || pop)
      else $error("result pushed into a full queue");

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for sliding_window_min_2d_unit: raster pixel requests in, window minima out
// depends on swm_pkg and the rtl of the unit; a local predictor tracks sizes, line minima and position

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import swm_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400_000;
   localparam int          DRAIN_CYCLES = PIPE_STAGES + 8;

   // indexes with no register behind them
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_INDEX = CSR_INDEX_BITS'(5);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TOP_INDEX   = '1;

   localparam pixel_type PIX_LOW = {1'b1, {(PIXEL_BITS - 1){1'b0}}};

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [TDATA_BITS-1:0]     req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [TDATA_BITS-1:0]     rsp_tdata;
   logic                      rsp_tlast;
   logic                      rsp_tuser;
   logic                      csr_we     = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata  = '0;

   // predictor copy of the sizes, as written (masked to register width)
   logic [IMAGE_WIDTH_BITS-1:0]  cfg_image_width   = IMAGE_WIDTH_BITS'(1024);
   logic [IMAGE_HEIGHT_BITS-1:0] cfg_image_height  = IMAGE_HEIGHT_BITS'(1024);
   logic [WINDOW_BITS-1:0]       cfg_window_height = WINDOW_BITS'(3);
   logic [WINDOW_BITS-1:0]       cfg_window_width  = WINDOW_BITS'(3);

   pixel_type   row_pixels [MAX_WINDOW_WIDTH];
   pixel_type   hmin_lines [LINE_COUNT][MAX_IMAGE_WIDTH];
   int unsigned col_pos = 0;
   int unsigned row_pos = 0;

   rsp_item_type expected_windows [$];

   int          fail_count    = 0;
   int unsigned cycle_count   = 0;
   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int unsigned hold_left     = 0;

   sliding_window_min_2d_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   task automatic predict_window(input pixel_type px);
      int unsigned w, h, wh, ww, c, r, slot;
      pixel_type   hmin, vmin;
      rsp_item_type item;
      w  = clamp_size(cfg_image_width, MAX_IMAGE_WIDTH);
      h  = clamp_size(cfg_image_height, MAX_IMAGE_HEIGHT);
      wh = clamp_size(cfg_window_height, MAX_WINDOW_HEIGHT);
      ww = clamp_size(cfg_window_width, MAX_WINDOW_WIDTH);
      c  = (col_pos >= w) ? w - 1 : col_pos;
      r  = (row_pos >= h) ? h - 1 : row_pos;
      for (int i = MAX_WINDOW_WIDTH - 1; i > 0; i--) row_pixels[i] = row_pixels[i - 1];
      row_pixels[0] = px;
      if (c + 1 >= ww) begin
         hmin = px;
         for (int i = 1; i < ww; i++) begin
            if (row_pixels[i] < hmin) hmin = row_pixels[i];
         end
         slot = r % LINE_COUNT;
         if (r + 1 >= wh) begin
            vmin = hmin;
            for (int d = 1; d < wh; d++) begin
               if (hmin_lines[(slot + LINE_COUNT - d) % LINE_COUNT][c] < vmin) begin
                  vmin = hmin_lines[(slot + LINE_COUNT - d) % LINE_COUNT][c];
               end
            end
            item.window_min = vmin;
            item.row_end    = (c == w - 1);
            item.frame_end  = (c == w - 1) && (r == h - 1);
            expected_windows.push_back(item);
         end
         hmin_lines[slot][c] = hmin;
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endtask

   function automatic pixel_type any_pixel();
      case ($urandom_range(7))
         0: return PIX_MAX;
         1: return PIX_LOW;
         // narrow range so that ties and near values are common
         2, 3: return pixel_type'($urandom_range(20)) - 10;
         default: return pixel_type'($urandom);
      endcase
   endfunction

   // register value with random bits above the field
   function automatic logic [CSR_DATA_BITS-1:0] with_noise(input int unsigned v,
                                                           input int unsigned bits);
      logic [CSR_DATA_BITS-1:0] noise;
      noise = CSR_DATA_BITS'($urandom);
      return (noise << bits) | CSR_DATA_BITS'(v);
   endfunction

   task automatic send_pixel(input pixel_type px);
      logic [TDATA_BITS-1:0] word;
      word = '0;
      word[PIXEL_BITS-1:0] = px;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      predict_window(px);
   endtask

   // only ever called with nothing in flight
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         CSR_IMAGE_WIDTH:   cfg_image_width   = data[IMAGE_WIDTH_BITS-1:0];
         CSR_IMAGE_HEIGHT:  cfg_image_height  = data[IMAGE_HEIGHT_BITS-1:0];
         CSR_WINDOW_HEIGHT: cfg_window_height = data[WINDOW_BITS-1:0];
         CSR_WINDOW_WIDTH:  cfg_window_width  = data[WINDOW_BITS-1:0];
         default: ;
      endcase
      // a size write restarts the frame, a spare index leaves the position alone
      if (idx <= CSR_WINDOW_WIDTH) begin
         col_pos = 0;
         row_pos = 0;
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_sizes(input int unsigned w, input int unsigned h,
                            input int unsigned wh, input int unsigned ww);
      write_csr(CSR_IMAGE_WIDTH, with_noise(w, IMAGE_WIDTH_BITS));
      write_csr(CSR_IMAGE_HEIGHT, with_noise(h, IMAGE_HEIGHT_BITS));
      write_csr(CSR_WINDOW_HEIGHT, with_noise(wh, WINDOW_BITS));
      write_csr(CSR_WINDOW_WIDTH, with_noise(ww, WINDOW_BITS));
   endtask

   // windows larger than the image leave nothing to wait for, so drain on top
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_windows.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_reset_sizes();
      // 1024 wide, 3x3 window: nothing due in the first rows
      repeat (48) send_pixel(any_pixel());
      wait_idle();
      // narrow rows, the window keeps its size from reset
      write_csr(CSR_IMAGE_WIDTH, with_noise(8, IMAGE_WIDTH_BITS));
      repeat (8 * 4) send_pixel(any_pixel());
      wait_idle();
   endtask

   task automatic test_pixel_extremes();
      pixel_type vals [8];
      vals = '{PIX_MAX, PIX_MAX, PIX_LOW, PIX_MAX, PIX_MAX, 0, -1, 1};
      set_sizes(3, 2, 2, 2);
      // last two pixels start the next frame
      foreach (vals[i]) send_pixel(vals[i]);
      wait_idle();
   endtask

   task automatic test_window_too_big();
      set_sizes(2, 2, 3, 3);
      repeat (4) send_pixel(any_pixel());
      wait_idle();
   endtask

   task automatic test_zero_sizes();
      set_sizes(0, 0, 0, 0);
      repeat (3) send_pixel(any_pixel());
      wait_idle();
   endtask

   task automatic test_csr_writes();
      set_sizes(3, 2, 2, 2);
      repeat (2) send_pixel(any_pixel());
      wait_idle();
      write_csr(CSR_SPARE_INDEX, CSR_DATA_BITS'($urandom));
      write_csr(CSR_TOP_INDEX, CSR_DATA_BITS'($urandom));
      repeat (2) send_pixel(any_pixel());
      wait_idle();
      // same width again, but the frame restarts mid-row
      write_csr(CSR_IMAGE_WIDTH, with_noise(3, IMAGE_WIDTH_BITS));
      repeat (6) send_pixel(any_pixel());
      wait_idle();
   endtask

   task automatic test_size_limits();
      set_sizes(1, 40, 63, 1);
      repeat (40) send_pixel(any_pixel());
      wait_idle();
      set_sizes(40, 1, 1, 63);
      repeat (40) send_pixel(any_pixel());
      wait_idle();
      // oversized width, rows wrap at the largest width
      set_sizes(2047, 1, 1, 32);
      repeat (1025) send_pixel(any_pixel());
      wait_idle();
   endtask

   task automatic test_backpressure();
      set_sizes(4, 4, 1, 1);
      // every request gives a result, so the unit fills and drops req_tready
      hold_left = 300;
      repeat (64) send_pixel(any_pixel());
      wait_idle();
   endtask

   task automatic test_random_frames(input int idle, input int stall, input int count);
      int unsigned w, h, wh, ww, n;
      int          sent;
      send_idle_pct = idle;
      stall_pct     = stall;
      sent          = 0;
      while (sent < count) begin
         if ($urandom_range(5) == 0) begin
            w  = $urandom_range(16, 40);
            h  = $urandom_range(2, 5);
            ww = $urandom_range(8, 32);
            wh = $urandom_range(1, h + 1);
         end else begin
            w  = $urandom_range(1, 10);
            h  = $urandom_range(1, 8);
            ww = $urandom_range(1, 4);
            wh = $urandom_range(1, 4);
         end
         n = $urandom_range(w * h / 2 + 1, 2 * w * h + 2);
         // a size of zero behaves as one
         if (w == 1 && $urandom_range(1)) w = 0;
         if (h == 1 && $urandom_range(1)) h = 0;
         if (wh == 1 && $urandom_range(1)) wh = 0;
         if (ww == 1 && $urandom_range(1)) ww = 0;
         set_sizes(w, h, wh, ww);
         repeat (n) send_pixel(any_pixel());
         sent += n;
         wait_idle();
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_windows.size() == 0) begin
            report_mismatch($sformatf("result %0d with no request pending",
                                      $signed(rsp_tdata[PIXEL_BITS-1:0])));
         end else begin
            want = expected_windows.pop_front();
            if (rsp_tdata[PIXEL_BITS-1:0] !== want.window_min) begin
               report_mismatch($sformatf("window_min %0d, expected %0d",
                                         $signed(rsp_tdata[PIXEL_BITS-1:0]),
                                         want.window_min));
            end
            if (rsp_tlast !== want.row_end) begin
               report_mismatch($sformatf("row_end %b, expected %b", rsp_tlast, want.row_end));
            end
            if (rsp_tuser !== want.frame_end) begin
               report_mismatch($sformatf("frame_end %b, expected %b",
                                         rsp_tuser, want.frame_end));
            end
         end
      end
   end

   // receiver: random stalls, plus one long hold counted down here
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_sizes();
      test_pixel_extremes();
      test_window_too_big();
      test_zero_sizes();
      test_csr_writes();
      test_size_limits();
      test_backpressure();
      test_random_frames(0, 0, 100);
      test_random_frames(72, 0, 100);
      test_random_frames(0, 72, 100);
      test_random_frames(15, 15, 100);
      wait_idle();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
